FILE: design/tps_pkg.sv
// Package for the tournament parent selector.
// Holds the sequencer state type, register indexes, input modes and config reset values.
// No dependencies.
package tps_pkg;

    localparam int unsigned POS_BITS  = 10;
    localparam int unsigned TAG_BITS  = 10;
    localparam int unsigned TSZ_BITS  = 5;
    localparam int unsigned PSZ_BITS  = 11;
    localparam int unsigned CFG_BITS  = 11;
    localparam int unsigned IDX_BITS  = 2;

    localparam logic [IDX_BITS-1:0] REG_MINIMISE        = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_TOURNAMENT_SIZE = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_POPULATION_SIZE = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    localparam logic                MINIMISE_RST        = 1'b0;
    localparam logic [TSZ_BITS-1:0] TOURNAMENT_SIZE_RST = 5'd2;
    localparam logic [PSZ_BITS-1:0] POPULATION_SIZE_RST = 11'd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT
    } tps_state_t;

endpackage

FILE: design/tournament_parent_selector.sv
// Tournament parent selector: fitness/tag tables, draw filter, leader compare, winner output.
// Depends on tps_pkg and tps_ram.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  in        in_valid / in_ready    mode, slot, fitness_value, tag, draw
//  out       out_valid / out_ready  winner_position, winner_tag, last
//  cfg       cfg_we                 cfg_index, cfg_data
//
// A load word or a discarded draw is taken while idle and leaves the sequencer idle; an accepted draw
// passes through ST_CMP, set by the registered fitness table read feeding the shared compare unit.
// A draw that closes a tournament also passes through ST_EMIT, waiting on the tag table read,
// and stays there while the output register is full under out_ready low.
// Reset clears the sequencer, counter and leader and loads the config reset values; the tables need no clearing.
module tournament_parent_selector
    import tps_pkg::*;
#(
    parameter int unsigned MAX_POPULATION = 1024,
    parameter int unsigned MAX_TOURNAMENT = 16,
    parameter int unsigned FITNESS_BITS   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [IDX_BITS-1:0]            cfg_index,
    input  logic [CFG_BITS-1:0]            cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [POS_BITS-1:0]            slot,
    input  logic signed [FITNESS_BITS-1:0] fitness_value,
    input  logic [TAG_BITS-1:0]            tag,
    input  logic [POS_BITS-1:0]            draw,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [POS_BITS-1:0]            winner_position,
    output logic [TAG_BITS-1:0]            winner_tag,
    output logic                           last
);

    localparam int unsigned AW = $clog2(MAX_POPULATION);
    localparam int unsigned TW = $clog2(MAX_TOURNAMENT);
    localparam int unsigned CW = $clog2(MAX_TOURNAMENT + 1);

    tps_state_t state_reg, state_next;

    logic                     minimise_reg;
    logic [TSZ_BITS-1:0]      tsize_reg;
    logic [PSZ_BITS-1:0]      psize_reg;

    logic [CW-1:0]            count_reg, count_next;
    logic [POS_BITS-1:0]      leader_pos_reg, leader_pos_next;
    logic signed [FITNESS_BITS-1:0] leader_val_reg, leader_val_next;
    logic                     parent_reg, parent_next;
    logic [POS_BITS-1:0]      pos_reg;
    logic [POS_BITS-1:0]      drawn_reg [MAX_TOURNAMENT];

    logic                     out_valid_reg, out_valid_next;
    logic [POS_BITS-1:0]      win_pos_reg;
    logic [TAG_BITS-1:0]      win_tag_reg;
    logic                     last_reg;

    logic                     accept;
    logic                     load_we;
    logic                     emit_load;
    logic                     draw_ok;
    logic                     dup_hit;
    logic                     better;
    logic                     take_leader;
    logic                     done;
    logic [PSZ_BITS-1:0]      eff_pop;
    logic [CW-1:0]            eff_tour;
    logic [CW-1:0]            count_inc;
    logic [31:0]              tour_calc;
    logic [31:0]              pop_calc;

    logic signed [FITNESS_BITS-1:0] fit_rdata;
    logic [TAG_BITS-1:0]      tag_rdata;
    logic [POS_BITS-1:0]      tag_raddr;

    tps_ram #(
        .WIDTH (FITNESS_BITS),
        .DEPTH (MAX_POPULATION)
    ) u_fit_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(slot)),
        .wdata (fitness_value),
        .raddr (AW'(draw)),
        .rdata (fit_rdata)
    );

    tps_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (MAX_POPULATION)
    ) u_tag_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(slot)),
        .wdata (tag),
        .raddr (AW'(tag_raddr)),
        .rdata (tag_rdata)
    );

    // effective population and tournament size
    always_comb
    begin
        pop_calc = {{(32-PSZ_BITS){1'b0}}, psize_reg};
        if (pop_calc > 32'(MAX_POPULATION))
        begin
            pop_calc = 32'(MAX_POPULATION);
        end
        eff_pop = PSZ_BITS'(pop_calc);

        tour_calc = (tsize_reg == '0) ? 32'd1 : {{(32-TSZ_BITS){1'b0}}, tsize_reg};
        if (tour_calc > 32'(MAX_TOURNAMENT))
        begin
            tour_calc = 32'(MAX_TOURNAMENT);
        end
        if (tour_calc > pop_calc)
        begin
            tour_calc = pop_calc;
        end
        eff_tour = CW'(tour_calc);
    end

    // draw filter: range and repeat check
    always_comb
    begin
        dup_hit = 1'b0;
        for (int i = 0; i < MAX_TOURNAMENT; i++)
        begin
            if ((CW'(i) < count_reg) && (drawn_reg[i] == draw))
            begin
                dup_hit = 1'b1;
            end
        end
        draw_ok = ({1'b0, draw} < eff_pop) && !dup_hit;
    end

    // shared compare unit
    always_comb
    begin
        better      = minimise_reg ? (fit_rdata < leader_val_reg) : (fit_rdata > leader_val_reg);
        take_leader = (count_reg == '0) || better;
        count_inc   = count_reg + CW'(1);
        done        = (count_inc >= eff_tour);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (mode == MODE_DRAW) && draw_ok)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = done ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = in_valid && in_ready;
        load_we   = accept && (mode == MODE_LOAD)
                    && ({{(32-POS_BITS){1'b0}}, slot} < 32'(MAX_POPULATION));
        emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        tag_raddr = (state_reg == ST_CMP) ? leader_pos_next : leader_pos_reg;
    end

    // leader, count and output next values
    always_comb
    begin
        count_next      = count_reg;
        leader_pos_next = leader_pos_reg;
        leader_val_next = leader_val_reg;
        parent_next     = parent_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if ((state_reg == ST_CMP) && take_leader)
        begin
            leader_pos_next = pos_reg;
            leader_val_next = fit_rdata;
        end
        if (state_reg == ST_CMP)
        begin
            count_next = done ? '0 : count_inc;
        end
        if (emit_load)
        begin
            out_valid_next = 1'b1;
            parent_next    = !parent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            minimise_reg   <= MINIMISE_RST;
            tsize_reg      <= TOURNAMENT_SIZE_RST;
            psize_reg      <= POPULATION_SIZE_RST;
            count_reg      <= '0;
            leader_pos_reg <= '0;
            leader_val_reg <= '0;
            parent_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            leader_pos_reg <= leader_pos_next;
            leader_val_reg <= leader_val_next;
            parent_reg     <= parent_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MINIMISE:        minimise_reg <= cfg_data[0];
                    REG_TOURNAMENT_SIZE: tsize_reg    <= cfg_data[TSZ_BITS-1:0];
                    REG_POPULATION_SIZE: psize_reg    <= cfg_data[PSZ_BITS-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= draw;
        end
        if ((state_reg == ST_CMP) && (count_reg < CW'(MAX_TOURNAMENT)))
        begin
            drawn_reg[count_reg[TW-1:0]] <= pos_reg;
        end
        if (emit_load)
        begin
            win_pos_reg <= leader_pos_reg;
            win_tag_reg <= tag_rdata;
            last_reg    <= parent_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign winner_position = win_pos_reg;
    assign winner_tag      = win_tag_reg;
    assign last            = last_reg;

endmodule

FILE: design/tps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tps_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
